FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: hdl/tpmh_pkg.sv
package tpmh_pkg;

	localparam int WORD_COUNT_DEF    = 4;
	localparam int SEQUENCE_BITS_DEF = 16;

	localparam int TIME_W   = 64;
	localparam int PER_W    = 16;
	localparam int STAT_W   = 32;
	localparam int WORD_W   = 5;
	localparam int SEQ_W    = 16;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	localparam logic [PER_W-1:0] TICK_RST      = 16'd10;
	localparam logic [PER_W-1:0] HEARTBEAT_RST = 16'd500;
	localparam logic [PER_W-1:0] FAULT_RST     = 16'd50;
	localparam logic [PER_W-1:0] TELEMETRY_RST = 16'd100;

	typedef enum logic [1:0] {
		REG_TICK,
		REG_HEARTBEAT,
		REG_FAULT_BLINK,
		REG_TELEMETRY
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_UPDATED   = 3'd0,
		ST_START     = 3'd1,
		ST_ZERO      = 3'd2,
		ST_BACKWARDS = 3'd3,
		ST_HALTED    = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EVAL,
		S_STATS,
		S_BLINK_CHK,
		S_BLINK_DIV,
		S_TELE_CHK,
		S_TELE_DIV,
		S_SEND,
		S_FINISH
	} fsm_t;

	typedef struct packed {
		logic [PER_W-1:0] tick;
		logic [PER_W-1:0] heartbeat;
		logic [PER_W-1:0] fault_blink;
		logic [PER_W-1:0] telemetry;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [TIME_W-1:0] dividend;
		logic [PER_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [PER_W-1:0] rem;
		logic             q_lsb;
	} div_rsp_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [STAT_W-1:0] period_last;
		logic [STAT_W-1:0] period_min;
		logic [STAT_W-1:0] period_max;
		logic [STAT_W-1:0] late;
		logic [TIME_W-1:0] total;
		logic              led;
		logic              take;
		logic [SEQ_W-1:0]  seq;
		logic [STAT_W-1:0] snap_period;
		logic [WORD_W-1:0] first;
		logic [WORD_W-1:0] sent;
	} res_t;

	function automatic logic [STAT_W-1:0] sat32(input logic [TIME_W-1:0] v);
		logic [STAT_W-1:0] r;
		r = (v[TIME_W-1:STAT_W] != '0) ? '1 : v[STAT_W-1:0];
		return r;
	endfunction

endpackage

FILE: hdl/tick_period_monitor_heartbeat_unit.sv
// Channel  | Handshake                       | Payload
// ---------+---------------------------------+----------------------------------------------
// config   | psel/penable/pwrite, pready=1   | paddr, pwdata, prdata
// tick in  | in_valid/in_ready               | now_ms, fault_active, fifo_free
// result   | out_valid/out_ready             | status ... words_sent
//
// One tick at a time; in_ready only while the sequencer is idle.
// Non-updating ticks go from EVAL to FINISH; an update passes STATS, BLINK_CHK, TELE_CHK and
// SEND, plus a run of the shared bit-serial 64/16 divider per due modulo (blink, telemetry).
// The result register frees the sequencer as soon as the previous beat is taken.
// Reset (arst_n low) loads register defaults, resets the monitor state, LED high.
module tick_period_monitor_heartbeat_unit #(
	parameter int WORD_COUNT    = tpmh_pkg::WORD_COUNT_DEF,
	parameter int SEQUENCE_BITS = tpmh_pkg::SEQUENCE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tpmh_pkg::ADDR_W-1:0]   paddr,
	input  logic [tpmh_pkg::DATA_W-1:0]   pwdata,
	output logic [tpmh_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tpmh_pkg::TIME_W-1:0]   now_ms,
	input  logic                          fault_active,
	input  logic [tpmh_pkg::WORD_W-1:0]   fifo_free,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    status,
	output logic [tpmh_pkg::STAT_W-1:0]   period_last_ms,
	output logic [tpmh_pkg::STAT_W-1:0]   period_min_ms,
	output logic [tpmh_pkg::STAT_W-1:0]   period_max_ms,
	output logic [tpmh_pkg::STAT_W-1:0]   late_count,
	output logic [tpmh_pkg::TIME_W-1:0]   total_elapsed_ms,
	output logic                          led_level,
	output logic                          snapshot_take,
	output logic [tpmh_pkg::SEQ_W-1:0]    snapshot_sequence,
	output logic [tpmh_pkg::STAT_W-1:0]   snapshot_period_ms,
	output logic [tpmh_pkg::WORD_W-1:0]   first_word,
	output logic [tpmh_pkg::WORD_W-1:0]   words_sent
);

	tpmh_pkg::cfg_t     cfg;
	tpmh_pkg::div_req_t div_req;
	tpmh_pkg::div_rsp_t div_rsp;
	tpmh_pkg::res_t     res;
	tpmh_pkg::res_t     out_q;
	logic               res_valid;
	logic               res_ready;
	logic               out_valid_q;

	tpmh_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tpmh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	tpmh_core #(
		.WORD_COUNT    (WORD_COUNT),
		.SEQUENCE_BITS (SEQUENCE_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.now_ms       (now_ms),
		.fault_active (fault_active),
		.fifo_free    (fifo_free),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.div_req      (div_req),
		.div_rsp      (div_rsp)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) out_q <= res;
	end

	assign out_valid          = out_valid_q;
	assign status             = out_q.status;
	assign period_last_ms     = out_q.period_last;
	assign period_min_ms      = out_q.period_min;
	assign period_max_ms      = out_q.period_max;
	assign late_count         = out_q.late;
	assign total_elapsed_ms   = out_q.total;
	assign led_level          = out_q.led;
	assign snapshot_take      = out_q.take;
	assign snapshot_sequence  = out_q.seq;
	assign snapshot_period_ms = out_q.snap_period;
	assign first_word         = out_q.first;
	assign words_sent         = out_q.sent;

endmodule

FILE: hdl/tpmh_cfg.sv
module tpmh_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tpmh_pkg::ADDR_W-1:0]   paddr,
	input  logic [tpmh_pkg::DATA_W-1:0]   pwdata,
	output logic [tpmh_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output tpmh_pkg::cfg_t                cfg
);

	tpmh_pkg::cfg_t     cfg_q;
	tpmh_pkg::reg_idx_t idx;
	logic               wr;

	assign idx    = tpmh_pkg::reg_idx_t'(paddr[3:2]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick        <= tpmh_pkg::TICK_RST;
			cfg_q.heartbeat   <= tpmh_pkg::HEARTBEAT_RST;
			cfg_q.fault_blink <= tpmh_pkg::FAULT_RST;
			cfg_q.telemetry   <= tpmh_pkg::TELEMETRY_RST;
		end else if (wr) begin
			unique case (idx)
				tpmh_pkg::REG_TICK:        cfg_q.tick        <= pwdata[tpmh_pkg::PER_W-1:0];
				tpmh_pkg::REG_HEARTBEAT:   cfg_q.heartbeat   <= pwdata[tpmh_pkg::PER_W-1:0];
				tpmh_pkg::REG_FAULT_BLINK: cfg_q.fault_blink <= pwdata[tpmh_pkg::PER_W-1:0];
				tpmh_pkg::REG_TELEMETRY:   cfg_q.telemetry   <= pwdata[tpmh_pkg::PER_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			tpmh_pkg::REG_TICK:        prdata = tpmh_pkg::DATA_W'(cfg_q.tick);
			tpmh_pkg::REG_HEARTBEAT:   prdata = tpmh_pkg::DATA_W'(cfg_q.heartbeat);
			tpmh_pkg::REG_FAULT_BLINK: prdata = tpmh_pkg::DATA_W'(cfg_q.fault_blink);
			tpmh_pkg::REG_TELEMETRY:   prdata = tpmh_pkg::DATA_W'(cfg_q.telemetry);
		endcase
	end

endmodule

FILE: hdl/tpmh_div.sv
`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle. Gives remainder and quotient lsb.
module tpmh_div (
	input  logic                clk,
	input  logic                arst_n,
	input  tpmh_pkg::div_req_t  req,
	output tpmh_pkg::div_rsp_t  rsp
);

	localparam int CNT_W = $clog2(tpmh_pkg::TIME_W);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [tpmh_pkg::TIME_W-1:0]   dvd_q;
	logic [tpmh_pkg::PER_W-1:0]    dsr_q;
	logic [tpmh_pkg::PER_W-1:0]    rem_q;
	logic                          qb_q;

	logic [tpmh_pkg::PER_W:0]      trial;
	logic                          ge;
	logic [tpmh_pkg::PER_W:0]      nrem;

	assign trial = {rem_q, dvd_q[tpmh_pkg::TIME_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign nrem  = ge ? (trial - {1'b0, dsr_q}) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(tpmh_pkg::TIME_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
			qb_q  <= 1'b0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[tpmh_pkg::TIME_W-2:0], 1'b0};
			rem_q <= nrem[tpmh_pkg::PER_W-1:0];
			qb_q  <= ge;
		end
	end

	assign rsp.done  = done_q;
	assign rsp.rem   = rem_q;
	assign rsp.q_lsb = qb_q;

	`ASSERT_PROP(a_rem_below_divisor, clk, arst_n, rsp.done |-> (rsp.rem < dsr_q), "remainder not below divisor")
	`ASSERT_NEVER(a_no_restart, clk, arst_n, req.start && busy_q, "divider restarted while busy")

endmodule

FILE: hdl/tpmh_core.sv
`include "assert_macros.svh"

module tpmh_core #(
	parameter int WORD_COUNT    = tpmh_pkg::WORD_COUNT_DEF,
	parameter int SEQUENCE_BITS = tpmh_pkg::SEQUENCE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tpmh_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tpmh_pkg::TIME_W-1:0]   now_ms,
	input  logic                          fault_active,
	input  logic [tpmh_pkg::WORD_W-1:0]   fifo_free,
	output logic                          res_valid,
	input  logic                          res_ready,
	output tpmh_pkg::res_t                res,
	output tpmh_pkg::div_req_t            div_req,
	input  tpmh_pkg::div_rsp_t            div_rsp
);

	localparam logic [tpmh_pkg::WORD_W-1:0] WC = tpmh_pkg::WORD_W'(WORD_COUNT);
	localparam int SEQ_EFF = (SEQUENCE_BITS >= tpmh_pkg::SEQ_W) ? tpmh_pkg::SEQ_W : SEQUENCE_BITS;
	localparam logic [tpmh_pkg::SEQ_W-1:0] SEQ_MASK =
		tpmh_pkg::SEQ_W'((33'd1 << SEQ_EFF) - 33'd1);

	tpmh_pkg::fsm_t                state_q, state_d;

	logic [tpmh_pkg::TIME_W-1:0]   now_q;
	logic                          fault_q;
	logic [tpmh_pkg::WORD_W-1:0]   room_q;
	logic [tpmh_pkg::TIME_W-1:0]   elapsed_q;

	logic                          started_q;
	logic                          halted_q;
	logic [tpmh_pkg::TIME_W-1:0]   prev_q;
	logic [tpmh_pkg::STAT_W-1:0]   last_q;
	logic [tpmh_pkg::STAT_W-1:0]   min_q;
	logic [tpmh_pkg::STAT_W-1:0]   max_q;
	logic [tpmh_pkg::STAT_W-1:0]   late_q;
	logic [tpmh_pkg::TIME_W-1:0]   total_q;
	logic [tpmh_pkg::TIME_W-1:0]   blink_q;
	logic                          led_q;
	logic [tpmh_pkg::TIME_W-1:0]   tele_q;
	logic [tpmh_pkg::WORD_W-1:0]   wp_q;
	logic [tpmh_pkg::TIME_W-1:0]   snap_prev_q;
	logic [tpmh_pkg::SEQ_W-1:0]    seq_q;
	logic [tpmh_pkg::SEQ_W-1:0]    cur_seq_q;
	logic [tpmh_pkg::STAT_W-1:0]   snap_per_q;
	tpmh_pkg::status_t             status_q;
	logic                          take_q;
	logic [tpmh_pkg::WORD_W-1:0]   first_q;
	logic [tpmh_pkg::WORD_W-1:0]   sent_q;

	logic [tpmh_pkg::TIME_W-1:0]   diff;
	logic                          backwards;
	logic [tpmh_pkg::STAT_W-1:0]   ep;
	logic [tpmh_pkg::PER_W-1:0]    blink_p;
	logic [tpmh_pkg::PER_W-1:0]    blink_p1;
	logic [tpmh_pkg::PER_W-1:0]    tele_p1;
	logic                          blink_hit;
	logic                          tele_hit;
	logic [tpmh_pkg::TIME_W-1:0]   snap_diff;
	logic [tpmh_pkg::WORD_W-1:0]   remaining;
	logic                          fill;

	assign diff      = now_q - prev_q;
	assign backwards = now_q < prev_q;
	assign ep        = tpmh_pkg::sat32(elapsed_q);
	assign blink_p   = fault_q ? cfg.fault_blink : cfg.heartbeat;
	assign blink_p1  = (blink_p == '0) ? tpmh_pkg::PER_W'(1) : blink_p;
	assign tele_p1   = (cfg.telemetry == '0) ? tpmh_pkg::PER_W'(1) : cfg.telemetry;
	assign blink_hit = blink_q >= tpmh_pkg::TIME_W'(blink_p1);
	assign tele_hit  = (wp_q >= WC) && (tele_q >= tpmh_pkg::TIME_W'(tele_p1));
	assign snap_diff = now_q - snap_prev_q;
	assign remaining = WC - wp_q;
	assign fill      = room_q >= remaining;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpmh_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		in_ready         = 1'b0;
		res_valid        = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = blink_q;
		div_req.divisor  = blink_p1;
		unique case (state_q)
			tpmh_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = tpmh_pkg::S_EVAL;
			end
			tpmh_pkg::S_EVAL: begin
				if (halted_q || !started_q || backwards || diff == '0)
					state_d = tpmh_pkg::S_FINISH;
				else
					state_d = tpmh_pkg::S_STATS;
			end
			tpmh_pkg::S_STATS: state_d = tpmh_pkg::S_BLINK_CHK;
			tpmh_pkg::S_BLINK_CHK: begin
				if (blink_hit) begin
					div_req.start = 1'b1;
					state_d       = tpmh_pkg::S_BLINK_DIV;
				end else begin
					state_d = tpmh_pkg::S_TELE_CHK;
				end
			end
			tpmh_pkg::S_BLINK_DIV: begin
				if (div_rsp.done) state_d = tpmh_pkg::S_TELE_CHK;
			end
			tpmh_pkg::S_TELE_CHK: begin
				div_req.dividend = tele_q;
				div_req.divisor  = tele_p1;
				if (tele_hit) begin
					div_req.start = 1'b1;
					state_d       = tpmh_pkg::S_TELE_DIV;
				end else begin
					state_d = tpmh_pkg::S_SEND;
				end
			end
			tpmh_pkg::S_TELE_DIV: begin
				if (div_rsp.done) state_d = tpmh_pkg::S_SEND;
			end
			tpmh_pkg::S_SEND: state_d = tpmh_pkg::S_FINISH;
			tpmh_pkg::S_FINISH: begin
				res_valid = 1'b1;
				if (res_ready) state_d = tpmh_pkg::S_IDLE;
			end
			default: state_d = tpmh_pkg::S_IDLE;
		endcase
	end

	// item payload, no reset
	always_ff @(posedge clk) begin
		if (state_q == tpmh_pkg::S_IDLE && in_valid) begin
			now_q   <= now_ms;
			fault_q <= fault_active;
			room_q  <= fifo_free;
		end
		if (state_q == tpmh_pkg::S_EVAL) elapsed_q <= diff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			halted_q    <= 1'b0;
			prev_q      <= '0;
			last_q      <= '0;
			min_q       <= '1;
			max_q       <= '0;
			late_q      <= '0;
			total_q     <= '0;
			blink_q     <= '0;
			led_q       <= 1'b1;
			tele_q      <= '0;
			wp_q        <= WC;
			snap_prev_q <= '0;
			seq_q       <= '0;
			cur_seq_q   <= '0;
			snap_per_q  <= '0;
			status_q    <= tpmh_pkg::ST_UPDATED;
			take_q      <= 1'b0;
			first_q     <= '0;
			sent_q      <= '0;
		end else begin
			if (state_q == tpmh_pkg::S_EVAL) begin
				take_q  <= 1'b0;
				sent_q  <= '0;
				first_q <= wp_q;
				priority if (halted_q) begin
					status_q <= tpmh_pkg::ST_HALTED;
				end else if (!started_q) begin
					started_q   <= 1'b1;
					prev_q      <= now_q;
					snap_prev_q <= now_q;
					status_q    <= tpmh_pkg::ST_START;
				end else if (backwards) begin
					halted_q <= 1'b1;
					led_q    <= 1'b1;
					status_q <= tpmh_pkg::ST_BACKWARDS;
				end else if (diff == '0) begin
					status_q <= tpmh_pkg::ST_ZERO;
				end else begin
					status_q <= tpmh_pkg::ST_UPDATED;
				end
			end
			if (state_q == tpmh_pkg::S_STATS) begin
				prev_q  <= now_q;
				last_q  <= ep;
				if (ep < min_q) min_q <= ep;
				if (ep > max_q) max_q <= ep;
				if (elapsed_q > tpmh_pkg::TIME_W'(cfg.tick)) late_q <= late_q + 1'b1;
				total_q <= total_q + elapsed_q;
				blink_q <= blink_q + elapsed_q;
				tele_q  <= tele_q + elapsed_q;
			end
			if (state_q == tpmh_pkg::S_BLINK_DIV && div_rsp.done) begin
				if (div_rsp.q_lsb) led_q <= ~led_q;
				blink_q <= tpmh_pkg::TIME_W'(div_rsp.rem);
			end
			if (state_q == tpmh_pkg::S_TELE_CHK && tele_hit) begin
				take_q      <= 1'b1;
				cur_seq_q   <= seq_q;
				wp_q        <= '0;
				snap_per_q  <= tpmh_pkg::sat32(snap_diff);
				snap_prev_q <= now_q;
			end
			if (state_q == tpmh_pkg::S_TELE_DIV && div_rsp.done) begin
				tele_q <= tpmh_pkg::TIME_W'(div_rsp.rem);
			end
			if (state_q == tpmh_pkg::S_SEND) begin
				first_q <= wp_q;
				if (wp_q < WC) begin
					if (fill) begin
						sent_q <= remaining;
						wp_q   <= WC;
						seq_q  <= (seq_q + 1'b1) & SEQ_MASK;
					end else begin
						sent_q <= room_q;
						wp_q   <= wp_q + room_q;
					end
				end
			end
		end
	end

	assign res.status      = status_q;
	assign res.period_last = last_q;
	assign res.period_min  = min_q;
	assign res.period_max  = max_q;
	assign res.late        = late_q;
	assign res.total       = total_q;
	assign res.led         = led_q;
	assign res.take        = take_q;
	assign res.seq         = cur_seq_q;
	assign res.snap_period = snap_per_q;
	assign res.first       = first_q;
	assign res.sent        = sent_q;

	`ASSERT_PROP(a_halt_sticky, clk, arst_n, halted_q |=> halted_q, "halt released without reset")
	`ASSERT_PROP(a_word_pos_range, clk, arst_n, wp_q <= WC, "word position past snapshot end")
	`ASSERT_PROP(a_blink_reduced, clk, arst_n, (state_q == tpmh_pkg::S_BLINK_DIV && div_rsp.done) |=> (blink_q < tpmh_pkg::TIME_W'(blink_p1)), "blink accumulator not reduced")

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import tpmh_pkg::*;

	localparam int NWORDS = WORD_COUNT_DEF;
	localparam logic [15:0] SEQ_MASK = (SEQUENCE_BITS_DEF >= 16) ? 16'hFFFF :
		16'((1 << SEQUENCE_BITS_DEF) - 1);
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int N_OPEN = 19;
	localparam int N_ROWS = 25;
	localparam int N_PHASES = 6;
	localparam int PHASE_ITEMS = 205;
	localparam logic [63:0] TIME_CEIL = 64'h4000_0000_0000_0000;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_ready;
	logic [TIME_W-1:0] now_ms;
	logic fault_active;
	logic [WORD_W-1:0] fifo_free;
	logic out_valid, out_ready;
	logic [2:0] status;
	logic [STAT_W-1:0] period_last_ms, period_min_ms, period_max_ms, late_count;
	logic [TIME_W-1:0] total_elapsed_ms;
	logic led_level, snapshot_take;
	logic [SEQ_W-1:0] snapshot_sequence;
	logic [STAT_W-1:0] snapshot_period_ms;
	logic [WORD_W-1:0] first_word, words_sent;

	tick_period_monitor_heartbeat_unit u_dut (.*);

	always #6 clk = ~clk;

	// timing monitor shadow
	cfg_t cfg;
	bit mon_started, mon_halted;
	logic [63:0] prev_stamp, snap_stamp, sum_elapsed, blink_acc, tele_acc;
	logic [31:0] per_last, per_min, per_max, late_cnt, snap_gap;
	logic led;
	logic [4:0] word_pos;
	logic [15:0] seq_next, seq_cur;

	res_t expected_reports[$];
	res_t got_beat, want_beat;
	int mismatch_count = 0;
	int idle_cycles = 0;
	bit no_idle = 1'b0;
	bit hold_request = 1'b0;
	logic [63:0] clock_ms = '0;

	typedef struct packed {
		bit abs_time;
		logic [63:0] stamp;
		logic fault;
		logic [4:0] room;
		status_t want_st;
		logic [31:0] want_last;
	} tick_row_t;

	// stamp is a gap from the previous tick unless abs_time is set
	tick_row_t script_rows [N_ROWS] = '{
		'{1'b1, 64'd0, 1'b0, 5'd0, ST_START, 32'd0},
		'{1'b0, 64'd0, 1'b0, 5'd0, ST_ZERO, 32'd0},
		'{1'b0, 64'd1, 1'b0, 5'd16, ST_UPDATED, 32'd1},
		'{1'b0, 64'd10, 1'b0, 5'd0, ST_UPDATED, 32'd10},
		'{1'b0, 64'd11, 1'b0, 5'd0, ST_UPDATED, 32'd11},
		'{1'b0, 64'd100, 1'b0, 5'd31, ST_UPDATED, 32'd100},
		'{1'b0, 64'd100, 1'b0, 5'd0, ST_UPDATED, 32'd100},
		'{1'b0, 64'd1, 1'b0, 5'd1, ST_UPDATED, 32'd1},
		'{1'b0, 64'd0, 1'b0, 5'd9, ST_ZERO, 32'd1},
		'{1'b0, 64'd2, 1'b1, 5'd2, ST_UPDATED, 32'd2},
		'{1'b0, 64'd50, 1'b1, 5'd1, ST_UPDATED, 32'd50},
		'{1'b0, 64'h1_0000_0000, 1'b1, 5'd16, ST_UPDATED, 32'hFFFF_FFFF},
		'{1'b0, 64'hFFFF_FFFF, 1'b0, 5'd3, ST_UPDATED, 32'hFFFF_FFFF},
		'{1'b0, 64'h1_0000_0005, 1'b0, 5'd20, ST_UPDATED, 32'hFFFF_FFFF},
		'{1'b0, 64'd499, 1'b0, 5'd5, ST_UPDATED, 32'd499},
		'{1'b0, 64'd500, 1'b0, 5'd17, ST_UPDATED, 32'd500},
		'{1'b0, 64'd1000, 1'b1, 5'd4, ST_UPDATED, 32'd1000},
		'{1'b0, 64'h100_0000_0000, 1'b0, 5'd0, ST_UPDATED, 32'hFFFF_FFFF},
		'{1'b0, 64'd7, 1'b0, 5'd31, ST_UPDATED, 32'd7},
		'{1'b1, ALL_ONES - 64'd1, 1'b1, 5'd16, ST_UPDATED, 32'hFFFF_FFFF},
		'{1'b1, ALL_ONES, 1'b0, 5'd0, ST_UPDATED, 32'd1},
		'{1'b1, ALL_ONES, 1'b1, 5'd31, ST_ZERO, 32'd1},
		'{1'b1, 64'd0, 1'b0, 5'd0, ST_BACKWARDS, 32'd1},
		'{1'b1, ALL_ONES, 1'b1, 5'd16, ST_HALTED, 32'd1},
		'{1'b1, 64'h5555_5555_5555_5555, 1'b0, 5'd7, ST_HALTED, 32'd1}
	};

	function automatic logic [31:0] clip_ms(input logic [63:0] v);
		return (v[63:32] != '0) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	function automatic void reset_monitor();
		cfg = '{16'd10, 16'd500, 16'd50, 16'd100};
		mon_started = 1'b0;
		mon_halted = 1'b0;
		prev_stamp = '0;
		snap_stamp = '0;
		sum_elapsed = '0;
		blink_acc = '0;
		tele_acc = '0;
		per_last = '0;
		per_min = '1;
		per_max = '0;
		late_cnt = '0;
		snap_gap = '0;
		led = 1'b1;
		word_pos = 5'(NWORDS);
		seq_next = '0;
		seq_cur = '0;
	endfunction

	function automatic res_t predict_tick(input logic [63:0] stamp, input logic flt,
			input logic [4:0] room);
		res_t r;
		logic [63:0] gap, bp, tp, q;
		logic [4:0] left, first_idx, sent;
		logic take;
		status_t st;
		left = room;
		sent = '0;
		take = 1'b0;
		st = ST_UPDATED;
		if (mon_halted) begin
			st = ST_HALTED;
		end else if (!mon_started) begin
			mon_started = 1'b1;
			prev_stamp = stamp;
			snap_stamp = stamp;
			st = ST_START;
		end else if (stamp < prev_stamp) begin
			mon_halted = 1'b1;
			led = 1'b1;
			st = ST_BACKWARDS;
		end else if (stamp == prev_stamp) begin
			st = ST_ZERO;
		end else begin
			gap = stamp - prev_stamp;
			prev_stamp = stamp;
			per_last = clip_ms(gap);
			if (per_last < per_min) per_min = per_last;
			if (per_last > per_max) per_max = per_last;
			if (gap > {48'd0, cfg.tick}) late_cnt++;
			sum_elapsed += gap;
			bp = flt ? 64'(cfg.fault_blink) : 64'(cfg.heartbeat);
			if (bp == '0) bp = 64'd1;
			blink_acc += gap;
			if (blink_acc >= bp) begin
				q = blink_acc / bp;
				if (q[0]) led = ~led;
				blink_acc = blink_acc % bp;
			end
			tp = (cfg.telemetry != '0) ? 64'(cfg.telemetry) : 64'd1;
			tele_acc += gap;
			if (word_pos >= 5'(NWORDS) && tele_acc >= tp) begin
				take = 1'b1;
				seq_cur = seq_next;
				word_pos = '0;
				tele_acc = tele_acc % tp;
				snap_gap = clip_ms(stamp - snap_stamp);
				snap_stamp = stamp;
			end
		end
		first_idx = word_pos;
		if (st == ST_UPDATED) begin
			while (word_pos < 5'(NWORDS) && left != '0) begin
				left--;
				sent++;
				word_pos++;
				if (word_pos >= 5'(NWORDS)) seq_next = (seq_next + 16'd1) & SEQ_MASK;
			end
		end
		r.status = st;
		r.period_last = per_last;
		r.period_min = per_min;
		r.period_max = per_max;
		r.late = late_cnt;
		r.total = sum_elapsed;
		r.led = led;
		r.take = take;
		r.seq = seq_cur;
		r.snap_period = snap_gap;
		r.first = first_idx;
		r.sent = sent;
		return r;
	endfunction

	task automatic send_tick(input logic [63:0] stamp, input logic flt, input logic [4:0] room,
			input bit typed, input status_t want_st, input logic [31:0] want_last);
		res_t want;
		in_valid <= 1'b1;
		now_ms <= stamp;
		fault_active <= flt;
		fifo_free <= room;
		do @(posedge clk); while (!in_ready);
		want = predict_tick(stamp, flt, room);
		if (typed) begin
			want.status = want_st;
			want.period_last = want_last;
		end
		expected_reports.push_back(want);
		if (!no_idle && $urandom_range(0, 99) < 37) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic play_rows(input int lo, input int hi);
		tick_row_t row;
		logic [63:0] stamp;
		int i;
		for (i = lo; i < hi; i++) begin
			row = script_rows[i];
			stamp = row.abs_time ? row.stamp : clock_ms + row.stamp;
			clock_ms = stamp;
			send_tick(stamp, row.fault, row.room, 1'b1, row.want_st, row.want_last);
		end
		in_valid <= 1'b0;
	endtask

	task automatic play_random(input int count);
		logic [63:0] gap;
		int pick, i;
		for (i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) gap = 64'd0;
			else if (pick < 62) gap = 64'($urandom_range(1, 40));
			else if (pick < 85)
				gap = 64'($urandom_range(1, 2 * int'(cfg.telemetry) + 2));
			else if (pick < 96)
				gap = 64'($urandom_range(1, 3 * int'(cfg.heartbeat) + 3));
			else gap = {$urandom, $urandom} >> $urandom_range(4, 30);
			if (gap > TIME_CEIL - clock_ms) gap = 64'd1;
			clock_ms += gap;
			pick = $urandom_range(0, 99);
			send_tick(clock_ms, $urandom_range(0, 99) < 30,
				(pick < 40) ? 5'd0 : (pick < 80) ? 5'($urandom_range(1, 4)) :
				5'($urandom_range(0, 31)), 1'b0, ST_UPDATED, '0);
		end
		in_valid <= 1'b0;
	endtask

	task automatic bus_transfer(input logic wr, input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [15:0] value);
		logic [DATA_W-1:0] rd;
		bus_transfer(1'b1, {idx, 2'b00}, {16'($urandom), value}, rd);
		case (idx)
			REG_TICK: cfg.tick = value;
			REG_HEARTBEAT: cfg.heartbeat = value;
			REG_FAULT_BLINK: cfg.fault_blink = value;
			REG_TELEMETRY: cfg.telemetry = value;
		endcase
		bus_transfer(1'b0, {idx, 2'b00}, '0, rd);
		if (rd !== {16'd0, value}) begin
			$display("%0t ns: readback %s expected %0h actual %0h", $time, idx.name(),
				{16'd0, value}, rd);
			mismatch_count++;
		end
	endtask

	task automatic program_phase(input int ph);
		logic [15:0] v;
		int k;
		for (k = 0; k < 4; k++) begin
			case (ph)
				0: v = 16'd1;
				1: v = 16'hFFFF;
				2: v = 16'd0;
				default: begin
					case (reg_idx_t'(k))
						REG_TICK: v = 16'($urandom_range(1, 60));
						REG_HEARTBEAT: v = 16'($urandom_range(1, 2000));
						REG_FAULT_BLINK: v = 16'($urandom_range(1, 300));
						default: v = 16'($urandom_range(1, 400));
					endcase
				end
			endcase
			reg_write(reg_idx_t'(k), v);
		end
	endtask

	task automatic wait_drained();
		while (expected_reports.size() != 0) @(posedge clk);
	endtask

	task automatic check_field(input string fname, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0h actual %0h", $time, fname, want, got);
			mismatch_count++;
		end
	endtask

	// result beats
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_beat = {status, period_last_ms, period_min_ms, period_max_ms, late_count,
				total_elapsed_ms, led_level, snapshot_take, snapshot_sequence,
				snapshot_period_ms, first_word, words_sent};
			if (expected_reports.size() == 0) begin
				$display("%0t ns: unexpected beat, expected none actual status %0d",
					$time, status);
				mismatch_count++;
			end else begin
				want_beat = expected_reports.pop_front();
				check_field("status", 64'(want_beat.status), 64'(got_beat.status));
				check_field("period_last_ms", 64'(want_beat.period_last),
					64'(got_beat.period_last));
				check_field("period_min_ms", 64'(want_beat.period_min),
					64'(got_beat.period_min));
				check_field("period_max_ms", 64'(want_beat.period_max),
					64'(got_beat.period_max));
				check_field("late_count", 64'(want_beat.late), 64'(got_beat.late));
				check_field("total_elapsed_ms", want_beat.total, got_beat.total);
				check_field("led_level", 64'(want_beat.led), 64'(got_beat.led));
				check_field("snapshot_take", 64'(want_beat.take), 64'(got_beat.take));
				check_field("snapshot_sequence", 64'(want_beat.seq), 64'(got_beat.seq));
				check_field("snapshot_period_ms", 64'(want_beat.snap_period),
					64'(got_beat.snap_period));
				check_field("first_word", 64'(want_beat.first), 64'(got_beat.first));
				check_field("words_sent", 64'(want_beat.sent), 64'(got_beat.sent));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("** tick_period_monitor_heartbeat_unit: FAILED **");
				$finish;
			end
		end
	end

	// result side backpressure
	initial begin
		int hold;
		hold = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= no_idle || ($urandom_range(0, 99) >= 37);
			end
		end
	end

	initial begin
		int ph;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		now_ms = '0;
		fault_active = 1'b0;
		fifo_free = '0;
		reset_monitor();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		play_rows(0, N_OPEN);
		for (ph = 0; ph < N_PHASES; ph++) begin
			wait_drained();
			program_phase(ph);
			no_idle = (ph == 4);
			if (ph == 2) hold_request = 1'b1;
			play_random(PHASE_ITEMS);
		end
		no_idle = 1'b0;
		// time backwards halts the block for the rest of the run
		play_rows(N_OPEN, N_ROWS);
		wait_drained();
		repeat (150) @(posedge clk);
		if (mismatch_count == 0)
			$display("** tick_period_monitor_heartbeat_unit: PASSED **");
		else
			$display("** tick_period_monitor_heartbeat_unit: FAILED **");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/tpmh_pkg.sv
hdl/tpmh_cfg.sv
hdl/tpmh_div.sv
hdl/tpmh_core.sv
hdl/tick_period_monitor_heartbeat_unit.sv
verif/tb_top.sv
